[src/vnt_pkg.sv]
// vnt_pkg: shared types, constants and helpers of the value noise turbulence engine
// used by vnt_tap, value_noise_turbulence_top, noise_checker and tb_top; no dependencies

package vnt_pkg;

    localparam int TABLE_ENTRIES  = 4096;
    localparam int ADDR_BITS      = $clog2(TABLE_ENTRIES);
    localparam int VALUE_BITS     = 16;
    localparam int MAX_DEPTH_LOG2 = 7;
    localparam int DEPTH_BITS     = 3;
    localparam int DIM_LOG2_MAX   = 6;
    localparam int DIM_BITS       = 3;
    localparam int COORD_BITS     = 16;
    localparam int CFG_DATA_BITS  = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OUT_BITS       = 16;

    // one side of a cell at the largest octave, and the bilinear weight area
    localparam int SIDE_BITS   = MAX_DEPTH_LOG2 + 1;
    localparam int FRAC_BITS   = MAX_DEPTH_LOG2;
    localparam int WEIGHT_BITS = 2 * MAX_DEPTH_LOG2 + 1;
    localparam int PROD_BITS   = WEIGHT_BITS + VALUE_BITS;
    localparam int ACC_BITS    = VALUE_BITS + 2 * MAX_DEPTH_LOG2 + 2;
    localparam int FSHIFT_BITS = $clog2(2 * MAX_DEPTH_LOG2 + 2);

    typedef enum logic [1:0] {
        MODE_BASE     = 2'd0,
        MODE_SMOOTH   = 2'd1,
        MODE_TURB     = 2'd2,
        MODE_TURB_RAW = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODE         = 2'd0,
        CFG_DEPTH_LOG2   = 2'd1,
        CFG_WIDTH_LOG2   = 2'd2,
        CFG_HEIGHT_LOG2  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RUN    = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one table read of the sequencer: address, bilinear weight, octave shift
    typedef struct packed {
        logic [ADDR_BITS-1:0]   addr;
        logic [WEIGHT_BITS-1:0] weight;
        logic [DEPTH_BITS-1:0]  shift;
    } tap_t;

    function automatic logic [DIM_BITS-1:0] dim_sat(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        r = (v > DIM_BITS'(DIM_LOG2_MAX)) ? DIM_BITS'(DIM_LOG2_MAX) : v;
        return r;
    endfunction

    function automatic logic [DEPTH_BITS-1:0] depth_sat(input logic [DEPTH_BITS-1:0] v);
        logic [DEPTH_BITS-1:0] r;
        r = (32'(v) > MAX_DEPTH_LOG2) ? DEPTH_BITS'(MAX_DEPTH_LOG2) : v;
        return r;
    endfunction

endpackage

[src/vnt_ram.sv]
// vnt_ram: generic single-port synchronous ram with registered read
// no dependencies

module vnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/vnt_tap.sv]
// vnt_tap: table address and bilinear weight for one corner of one octave
// depends on vnt_pkg

module vnt_tap (
    input  vnt_pkg::mode_t                    mode,
    input  logic [vnt_pkg::DEPTH_BITS-1:0]    depth,
    input  logic [vnt_pkg::DIM_BITS-1:0]      width_log2,
    input  logic [vnt_pkg::DIM_BITS-1:0]      height_log2,
    input  logic [vnt_pkg::DEPTH_BITS-1:0]    octave,
    input  logic [1:0]                        corner,
    input  logic [vnt_pkg::COORD_BITS-1:0]    coord_x,
    input  logic [vnt_pkg::COORD_BITS-1:0]    coord_y,
    output vnt_pkg::tap_t                     tap
);

    localparam int DM = vnt_pkg::DIM_LOG2_MAX;

    logic                             smooth;
    logic [vnt_pkg::DIM_BITS-1:0]     wl;
    logic [vnt_pkg::DIM_BITS-1:0]     hl;
    logic [vnt_pkg::COORD_BITS-1:0]   a;
    logic [vnt_pkg::COORD_BITS-1:0]   b;
    logic [vnt_pkg::COORD_BITS-1:0]   ax;
    logic [vnt_pkg::COORD_BITS-1:0]   by;
    logic [vnt_pkg::COORD_BITS-1:0]   fmask;
    logic [vnt_pkg::COORD_BITS-1:0]   fx_full;
    logic [vnt_pkg::COORD_BITS-1:0]   fy_full;
    logic [vnt_pkg::SIDE_BITS-1:0]    side;
    logic [vnt_pkg::SIDE_BITS-1:0]    fx;
    logic [vnt_pkg::SIDE_BITS-1:0]    fy;
    logic [vnt_pkg::SIDE_BITS-1:0]    wx;
    logic [vnt_pkg::SIDE_BITS-1:0]    wy;
    logic [2*vnt_pkg::SIDE_BITS-1:0]  area;
    logic [DM:0]                      wmask;
    logic [DM:0]                      hmask;
    logic [DM-1:0]                    xa;
    logic [DM-1:0]                    yb;

    always_comb
    begin
        smooth = (mode == vnt_pkg::MODE_SMOOTH) || (mode == vnt_pkg::MODE_TURB);
        wl     = vnt_pkg::dim_sat(width_log2);
        hl     = vnt_pkg::dim_sat(height_log2);

        a       = coord_x >> octave;
        b       = coord_y >> octave;
        fmask   = (vnt_pkg::COORD_BITS'(1) << octave) - vnt_pkg::COORD_BITS'(1);
        fx_full = coord_x & fmask;
        fy_full = coord_y & fmask;
        fx      = {1'b0, fx_full[vnt_pkg::FRAC_BITS-1:0]};
        fy      = {1'b0, fy_full[vnt_pkg::FRAC_BITS-1:0]};
        side    = vnt_pkg::SIDE_BITS'(1) << octave;

        // in the smoothed modes, corner bit 1 steps one cell left, bit 0 one cell up
        wx   = corner[1] ? (side - fx) : fx;
        wy   = corner[0] ? (side - fy) : fy;
        area = wx * wy;

        ax = (smooth && corner[1]) ? (a - vnt_pkg::COORD_BITS'(1)) : a;
        by = (smooth && corner[0]) ? (b - vnt_pkg::COORD_BITS'(1)) : b;

        wmask = ((DM+1)'(1) << wl) - (DM+1)'(1);
        hmask = ((DM+1)'(1) << hl) - (DM+1)'(1);
        xa    = ax[DM-1:0] & wmask[DM-1:0];
        yb    = by[DM-1:0] & hmask[DM-1:0];

        tap.addr = vnt_pkg::ADDR_BITS'(xa)
                 | (vnt_pkg::ADDR_BITS'(yb) << wl);

        if (smooth)
        begin
            tap.weight = area[vnt_pkg::WEIGHT_BITS-1:0];
        end
        else
        begin
            tap.weight = vnt_pkg::WEIGHT_BITS'(1) << octave;
        end

        tap.shift = (mode == vnt_pkg::MODE_TURB) ? (depth - octave)
                                                 : vnt_pkg::DEPTH_BITS'(0);
    end

endmodule

[src/value_noise_turbulence_top.sv]
// value_noise_turbulence_top: value noise engine with bilinear smoothing and turbulence
// depends on vnt_pkg, vnt_ram and vnt_tap
//
// channels: input beats carry op, table_index, table_value, coord_x, coord_y under
// in_valid / in_stall; result beats carry noise_value under out_valid / out_stall.
// a load beat (op 0) writes one entry of the 4096 x 16 noise table in the cycle it is
// taken and gives no result. a query beat (op 1) gives exactly one result beat.
// configuration registers (mode, depth_log2, table_width_log2, table_height_log2) are
// written through cfg_we / cfg_index / cfg_data; the user must write them only while no
// query is in flight; the block does not enforce it. throughput: one load per cycle
// when idle. a query issues table reads one per cycle from the single ram port, then
// drains a three-stage weight / multiply / accumulate pipeline: base: 1 read, smooth:
// 4 reads, turbulence: 4*(depth_log2+1) reads, turbulence without smoothing: depth_log2+1
// reads. after the last read a drain step waits until the last product is accumulated,
// then a finish step hands the result to the output register and goes back to idle.
// in_stall is high from query acceptance until the result is handed to the output register.
// the output register holds its beat while out_stall is high; the input side keeps
// taking beats meanwhile, and a later query waits in its last step until the register
// frees. reset clears control state and restores register defaults; the table is not
// cleared, and entries read by a query must be loaded first.

module value_noise_turbulence_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [vnt_pkg::ADDR_BITS-1:0]      table_index,
    input  logic [vnt_pkg::VALUE_BITS-1:0]     table_value,
    input  logic [vnt_pkg::COORD_BITS-1:0]     coord_x,
    input  logic [vnt_pkg::COORD_BITS-1:0]     coord_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [vnt_pkg::OUT_BITS-1:0]       noise_value,
    input  logic                               cfg_we,
    input  logic [vnt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vnt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    vnt_pkg::mode_t                     mode_reg;
    logic [vnt_pkg::DEPTH_BITS-1:0]     depth_reg;
    logic [vnt_pkg::DIM_BITS-1:0]       width_reg;
    logic [vnt_pkg::DIM_BITS-1:0]       height_reg;

    vnt_pkg::state_t                    state_reg;
    vnt_pkg::state_t                    state_next;
    logic [vnt_pkg::DEPTH_BITS-1:0]     k_reg;
    logic [vnt_pkg::DEPTH_BITS-1:0]     k_next;
    logic [1:0]                         corner_reg;
    logic [1:0]                         corner_next;
    logic [vnt_pkg::COORD_BITS-1:0]     x_reg;
    logic [vnt_pkg::COORD_BITS-1:0]     y_reg;

    logic                               valid1_reg;
    logic                               last1_reg;
    logic [vnt_pkg::WEIGHT_BITS-1:0]    weight1_reg;
    logic [vnt_pkg::DEPTH_BITS-1:0]     shift1_reg;
    logic                               valid2_reg;
    logic                               last2_reg;
    logic [vnt_pkg::PROD_BITS-1:0]      prod2_reg;
    logic [vnt_pkg::DEPTH_BITS-1:0]     shift2_reg;
    logic [vnt_pkg::ACC_BITS-1:0]       acc_reg;
    logic [vnt_pkg::ACC_BITS-1:0]       acc_next;

    logic                               out_valid_reg;
    logic [vnt_pkg::OUT_BITS-1:0]       noise_reg;

    logic                               in_accept;
    logic                               query_accept;
    logic                               load_accept;
    logic                               issue;
    logic                               last_issue;
    logic                               smooth;
    logic                               out_load;
    logic [vnt_pkg::DEPTH_BITS-1:0]     depth_eff;
    logic [vnt_pkg::DEPTH_BITS-1:0]     k_start;
    logic [vnt_pkg::DEPTH_BITS-1:0]     k_end;
    logic [vnt_pkg::FSHIFT_BITS-1:0]    fshift;
    logic [vnt_pkg::ACC_BITS-1:0]       acc_scaled;

    vnt_pkg::tap_t                      tap;
    logic                               ram_we;
    logic [vnt_pkg::ADDR_BITS-1:0]      ram_addr;
    logic [vnt_pkg::VALUE_BITS-1:0]     ram_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= vnt_pkg::MODE_TURB;
            depth_reg  <= vnt_pkg::DEPTH_BITS'(5);
            width_reg  <= vnt_pkg::DIM_BITS'(6);
            height_reg <= vnt_pkg::DIM_BITS'(6);
        end
        else if (cfg_we)
        begin
            unique case (vnt_pkg::cfg_idx_t'(cfg_index))
                vnt_pkg::CFG_MODE:        mode_reg   <= vnt_pkg::mode_t'(cfg_data[1:0]);
                vnt_pkg::CFG_DEPTH_LOG2:  depth_reg  <= cfg_data;
                vnt_pkg::CFG_WIDTH_LOG2:  width_reg  <= cfg_data;
                vnt_pkg::CFG_HEIGHT_LOG2: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign depth_eff = vnt_pkg::depth_sat(depth_reg);
    assign smooth    = (mode_reg == vnt_pkg::MODE_SMOOTH) || (mode_reg == vnt_pkg::MODE_TURB);
    assign k_start   = (mode_reg == vnt_pkg::MODE_SMOOTH) ? depth_eff
                                                         : vnt_pkg::DEPTH_BITS'(0);
    assign k_end     = (mode_reg == vnt_pkg::MODE_BASE) ? vnt_pkg::DEPTH_BITS'(0)
                                                       : depth_eff;

    always_comb
    begin
        case (mode_reg)
            vnt_pkg::MODE_SMOOTH: fshift = vnt_pkg::FSHIFT_BITS'({depth_eff, 1'b0});
            vnt_pkg::MODE_TURB:   fshift = vnt_pkg::FSHIFT_BITS'({depth_eff, 1'b1});
            vnt_pkg::MODE_TURB_RAW:
                fshift = vnt_pkg::FSHIFT_BITS'(depth_eff) + vnt_pkg::FSHIFT_BITS'(1);
            default:              fshift = '0;
        endcase
    end

    // sequencer
    assign in_stall     = (state_reg != vnt_pkg::ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign query_accept = in_accept && (op == vnt_pkg::OP_QUERY);
    assign load_accept  = in_accept && (op == vnt_pkg::OP_LOAD);
    assign issue        = (state_reg == vnt_pkg::ST_RUN);
    assign last_issue   = (k_reg == k_end) && (!smooth || (corner_reg == 2'd3));

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        corner_next = corner_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            vnt_pkg::ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next  = vnt_pkg::ST_RUN;
                    k_next      = k_start;
                    corner_next = 2'd0;
                end
            end
            vnt_pkg::ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = vnt_pkg::ST_DRAIN;
                end
                else if (!smooth || (corner_reg == 2'd3))
                begin
                    corner_next = 2'd0;
                    k_next      = k_reg + vnt_pkg::DEPTH_BITS'(1);
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                end
            end
            vnt_pkg::ST_DRAIN:
            begin
                if (valid2_reg && last2_reg)
                begin
                    state_next = vnt_pkg::ST_FINISH;
                end
            end
            vnt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = vnt_pkg::ST_IDLE;
                end
            end
            default: state_next = vnt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vnt_pkg::ST_IDLE;
            k_reg      <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            x_reg <= coord_x;
            y_reg <= coord_y;
        end
    end

    vnt_tap u_tap (
        .mode        (mode_reg),
        .depth       (depth_eff),
        .width_log2  (width_reg),
        .height_log2 (height_reg),
        .octave      (k_reg),
        .corner      (corner_reg),
        .coord_x     (x_reg),
        .coord_y     (y_reg),
        .tap         (tap)
    );

    // single port: loads write only while no query is in flight
    assign ram_we   = load_accept;
    assign ram_addr = load_accept ? table_index : tap.addr;

    vnt_ram #(
        .WIDTH (vnt_pkg::VALUE_BITS),
        .DEPTH (vnt_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (table_value),
        .rdata (ram_rdata)
    );

    // weight -> multiply -> accumulate pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            last1_reg  <= 1'b0;
            valid2_reg <= 1'b0;
            last2_reg  <= 1'b0;
        end
        else
        begin
            valid1_reg <= issue;
            last1_reg  <= issue && last_issue;
            valid2_reg <= valid1_reg;
            last2_reg  <= last1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        weight1_reg <= tap.weight;
        shift1_reg  <= tap.shift;
        prod2_reg   <= vnt_pkg::PROD_BITS'(weight1_reg * ram_rdata);
        shift2_reg  <= shift1_reg;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (query_accept)
        begin
            acc_next = '0;
        end
        else if (valid2_reg)
        begin
            acc_next = acc_reg + (vnt_pkg::ACC_BITS'(prod2_reg) << shift2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_scaled = acc_reg >> fshift;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            noise_reg <= acc_scaled[vnt_pkg::OUT_BITS-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    // a table write never overlaps reads of a query in flight
    a_no_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!valid1_reg && !valid2_reg))
        else $error("table write while reads in flight");

    // the result is taken only once the pipeline has drained
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vnt_pkg::ST_FINISH) |-> (!valid1_reg && !valid2_reg))
        else $error("result step with pipeline busy");

    // a new result beat comes only from the finish step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == vnt_pkg::ST_FINISH))
        else $error("result beat without finished query");

    // a pending result beat is not overwritten while stalled
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("stalled result overwritten");

endmodule

[verif/noise_checker.sv]
// noise_checker: watches the input, result and register ports of value_noise_turbulence_top,
// keeps its own copy of the noise table and registers, predicts every query and compares
// depends on vnt_pkg
`timescale 1ns / 100ps

module noise_checker
    import vnt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      op,
    input  logic [ADDR_BITS-1:0]      table_index,
    input  logic [VALUE_BITS-1:0]     table_value,
    input  logic [COORD_BITS-1:0]     coord_x,
    input  logic [COORD_BITS-1:0]     coord_y,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [OUT_BITS-1:0]       noise_value,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatches,
    output int                        pending
);

    logic [VALUE_BITS-1:0] noise_shadow [TABLE_ENTRIES];
    logic [OUT_BITS-1:0]   noise_expected_q [$];
    logic [OUT_BITS-1:0]   want;

    mode_t                 mode_q;
    logic [DEPTH_BITS-1:0] depth_q;
    logic [DIM_BITS-1:0]   width_q;
    logic [DIM_BITS-1:0]   height_q;

    // wrapped grid read, grid sides saturate at 64 entries
    function automatic logic [VALUE_BITS-1:0] table_at(input logic [63:0] a,
                                                       input logic [63:0] b);
        int          wl;
        int          hl;
        logic [63:0] idx;
        wl  = (width_q > DIM_LOG2_MAX) ? DIM_LOG2_MAX : int'(width_q);
        hl  = (height_q > DIM_LOG2_MAX) ? DIM_LOG2_MAX : int'(height_q);
        idx = (a & ((64'd1 << wl) - 64'd1)) + ((b & ((64'd1 << hl) - 64'd1)) << wl);
        return noise_shadow[idx[ADDR_BITS-1:0]];
    endfunction

    // bilinear sum at cell size 2^k, still scaled by 2^(2k)
    function automatic logic [63:0] bilinear_sum(input logic [63:0] x, input logic [63:0] y,
                                                 input int k);
        logic [63:0] s;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] fx;
        logic [63:0] fy;
        s  = 64'd1 << k;
        a  = x >> k;
        b  = y >> k;
        fx = x & (s - 64'd1);
        fy = y & (s - 64'd1);
        return fx * fy * 64'(table_at(a, b))
             + fx * (s - fy) * 64'(table_at(a, b - 64'd1))
             + (s - fx) * fy * 64'(table_at(a - 64'd1, b))
             + (s - fx) * (s - fy) * 64'(table_at(a - 64'd1, b - 64'd1));
    endfunction

    function automatic logic [OUT_BITS-1:0] predict_noise(input logic [COORD_BITS-1:0] cx,
                                                          input logic [COORD_BITS-1:0] cy);
        int          d;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] acc;
        d   = (depth_q > MAX_DEPTH_LOG2) ? MAX_DEPTH_LOG2 : int'(depth_q);
        x   = 64'(cx);
        y   = 64'(cy);
        acc = 64'd0;
        case (mode_q)
            MODE_BASE:   acc = 64'(table_at(x, y));
            MODE_SMOOTH: acc = bilinear_sum(x, y, d) >> (2 * d);
            MODE_TURB:
            begin
                for (int k = 0; k <= d; k++)
                    acc = acc + (bilinear_sum(x, y, k) << (d - k));
                acc = acc >> (2 * d + 1);
            end
            default:
            begin
                for (int k = 0; k <= d; k++)
                    acc = acc + (64'(table_at(x >> k, y >> k)) << k);
                acc = acc >> (d + 1);
            end
        endcase
        return acc[OUT_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q   = MODE_TURB;
            depth_q  = DEPTH_BITS'(5);
            width_q  = DIM_BITS'(6);
            height_q = DIM_BITS'(6);
            noise_expected_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:        mode_q   = mode_t'(cfg_data[1:0]);
                    CFG_DEPTH_LOG2:  depth_q  = cfg_data;
                    CFG_WIDTH_LOG2:  width_q  = cfg_data;
                    CFG_HEIGHT_LOG2: height_q = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (noise_expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, noise_value);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = noise_expected_q.pop_front();
                    if (noise_value !== want)
                    begin
                        $display("%0t: noise_value mismatch, expected %h actual %h",
                                 $time, want, noise_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (op == OP_LOAD)
                    noise_shadow[table_index] = table_value;
                else
                    noise_expected_q.push_back(predict_noise(coord_x, coord_y));
            end

            pending <= noise_expected_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
// tb_top: stimulus and verdict for value_noise_turbulence_top; fills the low noise table
// entries, then runs directed and random query/load phases under many register settings
// depends on vnt_pkg, value_noise_turbulence_top and noise_checker
`timescale 1ns / 100ps

module tb_top;
    import vnt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 48;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 14;
    localparam int FILL_ENTRIES = 256;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      op;
    logic [ADDR_BITS-1:0]      table_index;
    logic [VALUE_BITS-1:0]     table_value;
    logic [COORD_BITS-1:0]     coord_x;
    logic [COORD_BITS-1:0]     coord_y;
    logic                      out_valid;
    logic                      out_stall;
    logic [OUT_BITS-1:0]       noise_value;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int   mismatches;
    int   pending;
    int   cycle_count;
    bit   calm;
    bit   hold_off;

    value_noise_turbulence_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    noise_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL value_noise_turbulence_top");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return COORD_BITS'($urandom_range(0, 255));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return VALUE_BITS'($urandom);
    endfunction

    // valid stays high across back-to-back beats; it only drops for a gap
    task automatic send_beat(input logic o, input logic [ADDR_BITS-1:0] idx,
                             input logic [VALUE_BITS-1:0] val,
                             input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op          <= o;
        table_index <= idx;
        table_value <= val;
        coord_x     <= x;
        coord_y     <= y;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_load(input logic [ADDR_BITS-1:0] idx, input logic [VALUE_BITS-1:0] val);
        send_beat(OP_LOAD, idx, val, COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    task automatic send_query(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        send_beat(OP_QUERY, ADDR_BITS'($urandom), VALUE_BITS'($urandom), x, y);
    endtask

    // wait for every result, then let a trailing query or load drain out
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input mode_t m, input logic [2:0] d, input logic [2:0] w,
                              input logic [2:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= {1'b0, m};
        @(posedge clk);
        cfg_index <= CFG_DEPTH_LOG2;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= CFG_WIDTH_LOG2;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT_LOG2;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic corner_queries(input mode_t m);
        set_config(m, 3'd7, 3'd4, 3'd4);
        send_query('0, '0);
        send_query('1, '1);
        send_query('0, '1);
        send_query('1, '0);
        send_query(COORD_BITS'($urandom), COORD_BITS'($urandom));
        finish_phase();
    endtask

    task automatic random_phase(input mode_t m, input logic [2:0] d, input logic [2:0] w,
                                input logic [2:0] h, input bit quiet, input bit squeeze);
        set_config(m, d, w, h);
        calm = quiet;
        if (squeeze)
            hold_off = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(99) < 30)
                send_load(ADDR_BITS'($urandom), pick_value());
            else
                send_query(pick_coord(), pick_coord());
        end
        finish_phase();
        calm = 1'b0;
    endtask

    // result side: short stalls mostly, a few long ones, and one long hold-off on request
    initial
    begin
        int r;
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                r = $urandom_range(99);
                if (calm || r < 60)
                begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 8);
                end
                else if (r < 93)
                begin
                    out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    n = $urandom_range(15, 50);
                end
                // a hold-off request cuts the current stretch short
                for (int j = 0; j < n && !hold_off; j++)
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        calm        = 1'b1;
        hold_off    = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_LOAD;
        table_index <= '0;
        table_value <= '0;
        coord_x     <= '0;
        coord_y     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_MODE;
        cfg_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the low entries get values; every grid below spans at most that many entries
        for (int i = 0; i < FILL_ENTRIES; i++)
            send_load(ADDR_BITS'(i), VALUE_BITS'($urandom));
        calm = 1'b0;

        // corner values of a 16 x 16 grid, then queries at the coordinate extremes
        send_load('0, '1);
        send_load(ADDR_BITS'(255), '1);
        send_load(ADDR_BITS'(15), '0);
        send_load(ADDR_BITS'(240), VALUE_BITS'(16'h8000));
        finish_phase();
        corner_queries(MODE_BASE);
        corner_queries(MODE_SMOOTH);
        corner_queries(MODE_TURB);
        corner_queries(MODE_TURB_RAW);

        random_phase(MODE_BASE,     3'd0, 3'd1, 3'd1, 1'b0, 1'b1);
        random_phase(MODE_SMOOTH,   3'd0, 3'd6, 3'd2, 1'b1, 1'b0);
        random_phase(MODE_SMOOTH,   3'd7, 3'd4, 3'd4, 1'b0, 1'b0);
        random_phase(MODE_TURB,     3'd0, 3'd3, 3'd2, 1'b0, 1'b0);
        random_phase(MODE_TURB,     3'd7, 3'd2, 3'd6, 1'b0, 1'b0);
        random_phase(MODE_TURB_RAW, 3'd7, 3'd6, 3'd2, 1'b0, 1'b0);
        random_phase(MODE_TURB_RAW, 3'd0, 3'd1, 3'd6, 1'b0, 1'b0);
        random_phase(MODE_TURB,     3'd3, 3'd7, 3'd2, 1'b0, 1'b0);
        random_phase(MODE_SMOOTH,   3'd4, 3'd0, 3'd0, 1'b0, 1'b0);
        random_phase(MODE_BASE,     3'd2, 3'd2, 3'd7, 1'b0, 1'b0);
        random_phase(MODE_TURB_RAW, 3'd5, 3'd2, 3'd0, 1'b0, 1'b0);
        random_phase(MODE_TURB,     3'd7, 3'd1, 3'd1, 1'b0, 1'b0);

        if (mismatches == 0 && pending == 0)
            $display("PASS value_noise_turbulence_top");
        else
            $display("FAIL value_noise_turbulence_top");
        $finish;
    end

endmodule
